>>> src/utf8v_pkg.sv
`timescale 1ns / 1ps

package utf8v_pkg;

    localparam longint unsigned MAX_BYTES = 64'd65536;
    localparam longint unsigned POS_LIMIT_FULL = MAX_BYTES - 64'd1;
    localparam logic [15:0] POS_LIMIT =
        (POS_LIMIT_FULL > 64'hFFFF) ? 16'hFFFF : POS_LIMIT_FULL[15:0];

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD3_SURR  = 8'hED;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [7:0] CONT_MIN    = 8'h80;
    localparam logic [7:0] CONT_MAX    = 8'hBF;
    localparam logic [7:0] E0_CONT_MIN = 8'hA0;
    localparam logic [7:0] ED_CONT_MAX = 8'h9F;
    localparam logic [7:0] F0_CONT_MIN = 8'h90;
    localparam logic [7:0] F4_CONT_MAX = 8'h8F;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_START = 2'd1,
        ERR_CONT  = 2'd2,
        ERR_END   = 2'd3
    } err_code_t;

    typedef struct packed {
        logic       invalid;
        logic [1:0] len;
        logic [7:0] cont_lo;
        logic [7:0] cont_hi;
    } lead_info_t;

    typedef struct packed {
        logic        is_valid;
        err_code_t   code;
        logic [15:0] offset;
    } result_t;

endpackage

>>> src/utf8v_lead_decode.sv
`timescale 1ns / 1ps

module utf8v_lead_decode (
    input  logic [7:0]            data_byte,
    output utf8v_pkg::lead_info_t lead
);
    import utf8v_pkg::*;

    always_comb
    begin
        lead.invalid = 1'b0;
        lead.len     = 2'd0;
        lead.cont_lo = CONT_MIN;
        lead.cont_hi = CONT_MAX;
        unique case (data_byte) inside
            [8'h00:ASCII_MAX]:
            begin
                lead.len = 2'd0;
            end
            [LEAD2_MIN:LEAD2_MAX]:
            begin
                lead.len = 2'd1;
            end
            [LEAD3_MIN:LEAD3_MAX]:
            begin
                lead.len = 2'd2;
                if (data_byte == LEAD3_MIN)
                begin
                    lead.cont_lo = E0_CONT_MIN;
                end
                else if (data_byte == LEAD3_SURR)
                begin
                    lead.cont_hi = ED_CONT_MAX;
                end
            end
            [LEAD4_MIN:LEAD4_MAX]:
            begin
                lead.len = 2'd3;
                if (data_byte == LEAD4_MIN)
                begin
                    lead.cont_lo = F0_CONT_MIN;
                end
                else if (data_byte == LEAD4_MAX)
                begin
                    lead.cont_hi = F4_CONT_MAX;
                end
            end
            default:
            begin
                lead.invalid = 1'b1;
            end
        endcase
    end

endmodule

>>> src/utf8v_tracker.sv
`timescale 1ns / 1ps

module utf8v_tracker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  utf8v_pkg::lead_info_t  lead,
    output utf8v_pkg::result_t     result
);
    import utf8v_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] lead_pos_reg, lead_pos_next;
    logic [1:0]  remain_reg, remain_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  hi_reg, hi_next;
    logic        first_reg, first_next;
    logic        pend_reg, pend_next;
    logic        err_reg, err_next;
    err_code_t   code_reg, code_next;
    logic [15:0] offset_reg, offset_next;

    logic [7:0]  cur_lo;
    logic [7:0]  cur_hi;
    logic        pend_now;
    logic        fin_err;
    err_code_t   fin_code;
    logic [15:0] fin_offset;

    always_comb
    begin
        pos_next      = pos_reg;
        lead_pos_next = lead_pos_reg;
        remain_next   = remain_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        first_next    = first_reg;
        pend_next     = pend_reg;
        err_next      = err_reg;
        code_next     = code_reg;
        offset_next   = offset_reg;
        cur_lo        = first_reg ? lo_reg : CONT_MIN;
        cur_hi        = first_reg ? hi_reg : CONT_MAX;
        pend_now      = pend_reg || (data_byte < cur_lo) || (data_byte > cur_hi);

        if (!err_reg)
        begin
            if (remain_reg == 2'd0)
            begin
                if (lead.invalid)
                begin
                    err_next    = 1'b1;
                    code_next   = ERR_START;
                    offset_next = pos_reg;
                end
                else if (lead.len != 2'd0)
                begin
                    remain_next   = lead.len;
                    lead_pos_next = pos_reg;
                    lo_next       = lead.cont_lo;
                    hi_next       = lead.cont_hi;
                    first_next    = 1'b1;
                    pend_next     = 1'b0;
                end
            end
            else
            begin
                first_next  = 1'b0;
                remain_next = remain_reg - 2'd1;
                pend_next   = pend_now;
                if (remain_next == 2'd0 && pend_now)
                begin
                    err_next    = 1'b1;
                    code_next   = ERR_CONT;
                    offset_next = lead_pos_reg;
                    pend_next   = 1'b0;
                end
            end
        end

        if (pos_reg < POS_LIMIT)
        begin
            pos_next = pos_reg + 16'd1;
        end

        // string cut short inside a sequence
        fin_err    = err_next;
        fin_code   = code_next;
        fin_offset = offset_next;
        if (!err_next && remain_next != 2'd0)
        begin
            fin_err    = 1'b1;
            fin_code   = ERR_END;
            fin_offset = lead_pos_next;
        end

        result.is_valid = !fin_err;
        result.code     = fin_err ? fin_code : ERR_NONE;
        result.offset   = fin_err ? fin_offset : 16'd0;

        if (last_byte)
        begin
            pos_next      = 16'd0;
            lead_pos_next = 16'd0;
            remain_next   = 2'd0;
            lo_next       = CONT_MIN;
            hi_next       = CONT_MAX;
            first_next    = 1'b0;
            pend_next     = 1'b0;
            err_next      = 1'b0;
            code_next     = ERR_NONE;
            offset_next   = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 16'd0;
            lead_pos_reg <= 16'd0;
            remain_reg   <= 2'd0;
            lo_reg       <= CONT_MIN;
            hi_reg       <= CONT_MAX;
            first_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            err_reg      <= 1'b0;
            code_reg     <= ERR_NONE;
            offset_reg   <= 16'd0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            lead_pos_reg <= lead_pos_next;
            remain_reg   <= remain_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            first_reg    <= first_next;
            pend_reg     <= pend_next;
            err_reg      <= err_next;
            code_reg     <= code_next;
            offset_reg   <= offset_next;
        end
    end

endmodule

>>> src/utf8v_out_reg.sv
`timescale 1ns / 1ps

module utf8v_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  utf8v_pkg::result_t result,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               free,
    output logic               is_valid,
    output logic [1:0]         error_code,
    output logic [15:0]        error_offset
);
    import utf8v_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign is_valid     = data_reg.is_valid;
    assign error_code   = data_reg.code;
    assign error_offset = data_reg.offset;

endmodule

>>> src/utf8_strict_validator_top.sv
`timescale 1ns / 1ps
// channel | handshake             | payload
// in      | in_valid / in_ready   | data_byte[7:0], last_byte
// out     | out_valid / out_ready | is_valid, error_code[1:0], error_offset[15:0]
//
// one byte per clock while in_ready is high; the per-byte check and state update
// sit between the tracker state registers and the result register
// a result appears in the cycle after the transfer of the byte with last_byte set
// in_ready drops only while a result waits in the output register and
// out_ready is low
// reset clears all control state (the result payload is not reset); no clearing pass

module utf8_strict_validator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_valid,
    output logic [1:0]  error_code,
    output logic [15:0] error_offset
);
    import utf8v_pkg::*;

    lead_info_t lead;
    result_t    result;
    logic       step;
    logic       free;

    assign in_ready = free;
    assign step     = in_valid && in_ready;

    utf8v_lead_decode u_decode (
        .data_byte (data_byte),
        .lead      (lead)
    );

    utf8v_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .lead      (lead),
        .result    (result)
    );

    utf8v_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && last_byte),
        .result       (result),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .free         (free),
        .is_valid     (is_valid),
        .error_code   (error_code),
        .error_offset (error_offset)
    );

endmodule

>>> verif/utf8_strict_validator_top_tb.sv
`timescale 1ns / 1ps

module utf8_strict_validator_top_tb;

    import utf8v_pkg::*;

    class utf8_verdict_scoreboard;
        logic [15:0] str_pos;
        logic [15:0] lead_pos;
        logic [1:0]  conts_left;
        logic [7:0]  first_lo;
        logic [7:0]  first_hi;
        bit          at_first;
        bit          cont_bad;
        bit          err_seen;
        err_code_t   err_kind;
        logic [15:0] err_pos;
        result_t     expected_verdicts[$];
        int          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            str_pos    = '0;
            lead_pos   = '0;
            conts_left = '0;
            first_lo   = CONT_MIN;
            first_hi   = CONT_MAX;
            at_first   = 1'b0;
            cont_bad   = 1'b0;
            err_seen   = 1'b0;
            err_kind   = ERR_NONE;
            err_pos    = '0;
        endfunction

        function void note_error(err_code_t kind, logic [15:0] pos);
            err_seen = 1'b1;
            err_kind = kind;
            err_pos  = pos;
        endfunction

        // notes one input transfer and queues the verdict on the last byte
        function void take_byte(logic [7:0] b, logic last);
            logic [1:0] len;
            logic [7:0] lo;
            logic [7:0] hi;
            result_t    verdict;
            len = 2'd0;
            lo  = CONT_MIN;
            hi  = CONT_MAX;
            if (!err_seen)
            begin
                if (conts_left == 2'd0)
                begin
                    if (b <= ASCII_MAX)
                        len = 2'd0;
                    else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
                        len = 2'd1;
                    else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
                    begin
                        len = 2'd2;
                        if (b == LEAD3_MIN)
                            lo = E0_CONT_MIN;
                        else if (b == LEAD3_SURR)
                            hi = ED_CONT_MAX;
                    end
                    else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
                    begin
                        len = 2'd3;
                        if (b == LEAD4_MIN)
                            lo = F0_CONT_MIN;
                        else if (b == LEAD4_MAX)
                            hi = F4_CONT_MAX;
                    end
                    else
                        note_error(ERR_START, str_pos);
                    if (len != 2'd0)
                    begin
                        conts_left = len;
                        lead_pos   = str_pos;
                        first_lo   = lo;
                        first_hi   = hi;
                        at_first   = 1'b1;
                        cont_bad   = 1'b0;
                    end
                end
                else
                begin
                    if (at_first)
                    begin
                        lo = first_lo;
                        hi = first_hi;
                    end
                    if (b < lo || b > hi)
                        cont_bad = 1'b1;
                    at_first   = 1'b0;
                    conts_left = conts_left - 2'd1;
                    if (conts_left == 2'd0 && cont_bad)
                    begin
                        note_error(ERR_CONT, lead_pos);
                        cont_bad = 1'b0;
                    end
                end
            end
            if (str_pos < POS_LIMIT)
                str_pos = str_pos + 16'd1;
            if (last)
            begin
                if (!err_seen && conts_left != 2'd0)
                    note_error(ERR_END, lead_pos);
                verdict.is_valid = !err_seen;
                verdict.code     = err_seen ? err_kind : ERR_NONE;
                verdict.offset   = err_seen ? err_pos : 16'd0;
                expected_verdicts.push_back(verdict);
                restart();
            end
        endfunction

        function void check_verdict(logic v, logic [1:0] code, logic [15:0] off);
            result_t want;
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none expected: is_valid=%0d code=%0d offset=%0d",
                             $realtime, v, code, off);
                return;
            end
            want = expected_verdicts.pop_front();
            if (v !== want.is_valid || code !== want.code || off !== want.offset)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected is_valid=%0d code=%0d offset=%0d, got %0d %0d %0d",
                             $realtime, want.is_valid, want.code, want.offset, v, code, off);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic        is_valid;
    logic [1:0]  error_code;
    logic [15:0] error_offset;

    utf8_verdict_scoreboard sb;
    logic [7:0] text[$];
    int send_idle = 28;
    int recv_idle = 78;
    int hold_left = 0;
    int bytes_sent = 0;

    utf8_strict_validator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_valid     (is_valid),
        .error_code   (error_code),
        .error_offset (error_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off when requested
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_byte(data_byte, last_byte);
            if (out_valid && out_ready)
                sb.check_verdict(is_valid, error_code, error_offset);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
    endtask

    // appends one well-formed character, leaning on the tightened leads
    function automatic void add_char();
        logic [7:0] lead;
        case ($urandom_range(3))
            0: text.push_back(8'($urandom_range(ASCII_MAX)));
            1:
            begin
                text.push_back(8'($urandom_range(LEAD2_MAX, LEAD2_MIN)));
                text.push_back(8'($urandom_range(CONT_MAX, CONT_MIN)));
            end
            2:
            begin
                case ($urandom_range(3))
                    0: lead = LEAD3_MIN;
                    1: lead = LEAD3_SURR;
                    default: lead = 8'($urandom_range(LEAD3_MAX, LEAD3_MIN));
                endcase
                text.push_back(lead);
                if (lead == LEAD3_MIN)
                    text.push_back(8'($urandom_range(CONT_MAX, E0_CONT_MIN)));
                else if (lead == LEAD3_SURR)
                    text.push_back(8'($urandom_range(ED_CONT_MAX, CONT_MIN)));
                else
                    text.push_back(8'($urandom_range(CONT_MAX, CONT_MIN)));
                text.push_back(8'($urandom_range(CONT_MAX, CONT_MIN)));
            end
            default:
            begin
                case ($urandom_range(3))
                    0: lead = LEAD4_MIN;
                    1: lead = LEAD4_MAX;
                    default: lead = 8'($urandom_range(LEAD4_MAX, LEAD4_MIN));
                endcase
                text.push_back(lead);
                if (lead == LEAD4_MIN)
                    text.push_back(8'($urandom_range(CONT_MAX, F0_CONT_MIN)));
                else if (lead == LEAD4_MAX)
                    text.push_back(8'($urandom_range(F4_CONT_MAX, CONT_MIN)));
                else
                    text.push_back(8'($urandom_range(CONT_MAX, CONT_MIN)));
                repeat (2) text.push_back(8'($urandom_range(CONT_MAX, CONT_MIN)));
            end
        endcase
    endfunction

    task automatic send_random_string();
        int pick;
        int mark;
        int cut;
        text.delete();
        pick = $urandom_range(99);
        if (pick >= 94)
            repeat ($urandom_range(6, 1)) text.push_back(8'($urandom));
        else
        begin
            repeat ($urandom_range(6, 1)) add_char();
            if (pick >= 82)
            begin
                // string ends inside a sequence, sometimes with a bad continuation
                mark = text.size();
                add_char();
                if (text.size() - mark > 1)
                begin
                    cut = $urandom_range(text.size() - mark - 1, 1);
                    repeat (cut) void'(text.pop_back());
                    if (pick >= 88 && text.size() - mark > 1)
                        text[text.size() - 1] = 8'($urandom);
                end
            end
            else if (pick >= 70)
                text[$urandom_range(text.size() - 1)] = 8'($urandom);
        end
        send_text();
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        last_byte <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        text = {8'h00, 8'h7F};
        send_text();
        text = {8'hC1};
        send_text();
        text = {8'h41, 8'h80};
        send_text();
        text = {8'hF5, 8'hFF};
        send_text();
        text = {8'hE0, 8'h9F, 8'h80};
        send_text();
        text = {8'hED, 8'hA0, 8'h80};
        send_text();
        text = {8'hF4, 8'h90, 8'h80, 8'h80};
        send_text();
        text = {8'h41, 8'hE0, 8'h80};
        send_text();
        text = {8'hF0, 8'h90, 8'h80};
        send_text();

        while (bytes_sent < 250)
            send_random_string();
        send_idle = 78;
        recv_idle = 28;
        while (bytes_sent < 500)
            send_random_string();
        send_idle = 0;
        recv_idle = 0;

        // long receiver hold-off while single-byte strings keep coming
        hold_left = 400;
        repeat (40)
        begin
            text = {8'($urandom_range(ASCII_MAX))};
            send_text();
        end
        while (bytes_sent < 750)
            send_random_string();
        in_valid <= 1'b0;

        while (sb.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/utf8v_pkg.sv
src/utf8v_lead_decode.sv
src/utf8v_tracker.sv
src/utf8v_out_reg.sv
src/utf8_strict_validator_top.sv
verif/utf8_strict_validator_top_tb.sv
